FILE: rtl/ic_pkg.sv
// Package for the inversion counter: payload structs, the token that travels
// down the cell chain, and sizing constants. No dependencies.
package ic_pkg;

  localparam int unsigned MaxItemsDefault = 1024;
  localparam int unsigned ValueW          = 64;
  localparam int unsigned InvW            = 19;
  localparam int unsigned ResDepth        = 4;
  localparam int unsigned ResPtrW         = $clog2(ResDepth);
  localparam int unsigned ResCntW         = $clog2(ResDepth + 1);

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     last;
  } ic_in_t;

  typedef struct packed {
    logic [InvW-1:0] inversions;
    logic            overflow;
  } ic_out_t;

  typedef struct packed {
    logic                     vld;
    logic signed [ValueW-1:0] value;
    logic                     last;
    logic                     cmp;
    logic                     placed;
    logic                     ovf;
  } ic_tok_t;

endpackage

FILE: rtl/ic_cell.sv
// One cell of the comparison chain: holds one stored value, counts a passing
// token against it and hands the token on. Depends on ic_pkg.
module ic_cell #(
  parameter int unsigned CntW = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ic_pkg::ic_tok_t tok_i,
  input  logic [CntW-1:0] cnt_i,
  output ic_pkg::ic_tok_t tok_o,
  output logic [CntW-1:0] cnt_o
);
  import ic_pkg::*;

  logic signed [ValueW-1:0] val_q;
  logic                     full_q, full_d;
  ic_tok_t                  tok_q, tok_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     hit, store;

  always_comb begin
    hit    = tok_i.vld && tok_i.cmp && full_q && (val_q > tok_i.value);
    store  = tok_i.vld && !tok_i.placed && !full_q;
    tok_d  = tok_i;
    cnt_d  = cnt_i + CntW'(hit);
    full_d = full_q;
    if (store) begin
      tok_d.placed = 1'b1;
      full_d       = 1'b1;
    end
    if (tok_i.vld && tok_i.last) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      tok_q  <= '0;
      cnt_q  <= '0;
    end else begin
      full_q <= full_d;
      tok_q  <= tok_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      val_q <= tok_i.value;
    end
  end

  assign tok_o = tok_q;
  assign cnt_o = cnt_q;

endmodule

FILE: rtl/ic_tail.sv
// Tail of the chain: sums per-token counts into the running total and queues
// one result beat per finished sequence. Depends on ic_pkg.
module ic_tail #(
  parameter int unsigned CntW = 10
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ic_pkg::ic_tok_t tok_i,
  input  logic [CntW-1:0] cnt_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ic_pkg::ic_out_t out_data_o
);
  import ic_pkg::*;

  logic [InvW-1:0]    total_q, total_d;
  logic [InvW:0]      sum;
  logic [InvW-1:0]    sat;
  ic_out_t            res_q [ResDepth];
  logic [ResPtrW-1:0] wr_q, rd_q;
  logic [ResCntW-1:0] num_q;
  logic               push, pop;

  always_comb begin
    sum     = {1'b0, total_q} + (InvW+1)'(cnt_i);
    sat     = sum[InvW] ? '1 : sum[InvW-1:0];
    push    = tok_i.vld && tok_i.last;
    pop     = out_valid_o && !out_stall_i;
    total_d = total_q;
    if (tok_i.vld) begin
      total_d = push ? '0 : sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      wr_q    <= '0;
      rd_q    <= '0;
      num_q   <= '0;
    end else begin
      total_q <= total_d;
      if (push) begin
        wr_q <= wr_q + ResPtrW'(1);
      end
      if (pop) begin
        rd_q <= rd_q + ResPtrW'(1);
      end
      num_q <= num_q + ResCntW'(push) - ResCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      res_q[wr_q] <= '{inversions: sat, overflow: tok_i.ovf};
    end
  end

  assign out_valid_o = (num_q != '0);
  assign out_data_o  = res_q[rd_q];

endmodule

FILE: rtl/inversion_counter_core.sv
// Inversion counter top level: entry logic, the chain of ic_cell and ic_tail.
// Depends on ic_pkg, ic_cell and ic_tail.
//
// Usage: input beats carry one signed 64-bit value and a last flag; the beat
// with last set closes a sequence and yields one output beat holding the
// number of pairs whose earlier value is strictly greater than the later one,
// plus a flag set when values beyond MAX_ITEMS were dropped.
// Each accepted beat not dropped beyond MAX_ITEMS enters a token that walks
// the chain of MAX_ITEMS cells, one cell a cycle, counting against the value
// in every occupied cell; a non-closing token settles in the first free one.
// The closing token empties the cells as it passes, so the next sequence may
// follow in the very next cycle. Throughput: one input beat per cycle while
// in_stall_o is low; a result is offered once it has passed the whole chain.
// Up to ResDepth results may be in flight or queued; once that many are
// outstanding, in_stall_o is held high until the receiver takes one.
// A stalled output beat holds; the chain keeps moving while it waits.
// Reset empties all cells, the counts and the result queue at once.
module inversion_counter_core #(
  parameter int unsigned MAX_ITEMS = ic_pkg::MaxItemsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ic_pkg::ic_in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ic_pkg::ic_out_t out_data_o
);
  import ic_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_ITEMS);
  localparam int unsigned FillW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned CrdW  = $clog2(ResDepth + 1);

  logic [FillW-1:0] fill_q, fill_d;
  logic             ovf_q, ovf_d;
  logic [CrdW-1:0]  crd_q;
  logic             in_beat, out_beat, full;
  ic_tok_t          head_q, head_d;
  ic_tok_t          tok [MAX_ITEMS+1];
  logic [CntW-1:0]  cnt [MAX_ITEMS+1];

  assign in_stall_o = (crd_q == CrdW'(ResDepth));
  assign in_beat    = in_valid_i && !in_stall_o;
  assign out_beat   = out_valid_o && !out_stall_i;
  assign full       = (fill_q == FillW'(MAX_ITEMS));

  always_comb begin
    head_d        = '0;
    head_d.value  = in_data_i.value;
    head_d.last   = in_data_i.last;
    head_d.cmp    = !full;
    head_d.placed = in_data_i.last || full;
    head_d.ovf    = ovf_q || full;
    head_d.vld    = in_beat && (!full || in_data_i.last);
    fill_d        = fill_q;
    ovf_d         = ovf_q;
    if (in_beat) begin
      if (in_data_i.last) begin
        fill_d = '0;
        ovf_d  = 1'b0;
      end else if (full) begin
        ovf_d = 1'b1;
      end else begin
        fill_d = fill_q + FillW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ovf_q  <= 1'b0;
      crd_q  <= '0;
      head_q <= '0;
    end else begin
      fill_q <= fill_d;
      ovf_q  <= ovf_d;
      crd_q  <= crd_q + CrdW'(in_beat && in_data_i.last) - CrdW'(out_beat);
      head_q <= head_d;
    end
  end

  assign tok[0] = head_q;
  assign cnt[0] = '0;

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    ic_cell #(
      .CntW (CntW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[g]),
      .cnt_i  (cnt[g]),
      .tok_o  (tok[g+1]),
      .cnt_o  (cnt[g+1])
    );
  end

  ic_tail #(
    .CntW (CntW)
  ) u_tail (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok[MAX_ITEMS]),
    .cnt_i       (cnt[MAX_ITEMS]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_crd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crd_q <= CrdW'(ResDepth))
    else $error("result credits exceed queue depth");

  a_out_has_crd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> crd_q != '0)
    else $error("result offered without a reserved slot");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(MAX_ITEMS))
    else $error("fill count beyond store size");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && in_data_i.last |=> fill_q == '0 && !ovf_q)
    else $error("sequence state not cleared after closing beat");

endmodule
